// ----- hdl/jddq_pkg.sv -----
// Package for the joystick dead-zone direction qualifier.
// Holds the controller states, the register indexes, the command and status
// structs, the reset values of the settings and the tilt window bounds.
`default_nettype none

package jddq_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PREP,
      ST_DIVIDE,
      ST_COMMIT
   } jddq_state_type;

   typedef enum logic [2:0] {
      REG_DEAD_HIGH_X = 3'd0,
      REG_DEAD_LOW_X  = 3'd1,
      REG_DEAD_HIGH_Y = 3'd2,
      REG_DEAD_LOW_Y  = 3'd3,
      REG_SPAN_HIGH_X = 3'd4,
      REG_SPAN_LOW_X  = 3'd5,
      REG_SPAN_HIGH_Y = 3'd6,
      REG_SPAN_LOW_Y  = 3'd7
   } jddq_reg_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic prep;
      logic step;
      logic commit;
   } jddq_cmd_type;

   typedef struct packed {
      logic out_busy;
   } jddq_status_type;

   localparam int AXES = 2;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;

   localparam logic [7:0] DEAD_HIGH_RESET = 8'd140;
   localparam logic [7:0] DEAD_LOW_RESET  = 8'd116;
   localparam logic [7:0] SPAN_HIGH_RESET = 8'd115;
   localparam logic [7:0] SPAN_LOW_RESET  = 8'd116;

   localparam logic signed [12:0] ROLL_SIDE_MIN  = 13'sd640;
   localparam logic signed [12:0] ROLL_SIDE_MAX  = 13'sd1920;
   localparam logic signed [12:0] PITCH_FLAT_MAX = 13'sd880;
   localparam logic signed [12:0] PITCH_TILT_MIN = 13'sd560;
   localparam logic signed [12:0] PITCH_TILT_MAX = 13'sd1440;

endpackage

`default_nettype wire

// ----- hdl/jddq_ctrl.sv -----
// Controller state machine of the joystick dead-zone direction qualifier.
// Sequences capture, setup, prep, divider iterations and commit; uses jddq_pkg.
`default_nettype none

module jddq_ctrl #(
   parameter int DIV_STEPS = 23
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire jddq_pkg::jddq_status_type status,
   output jddq_pkg::jddq_cmd_type        cmd
);
   import jddq_pkg::*;

   localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   jddq_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            count_in = CNT_W'(DIV_STEPS - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (count_ff == '0) begin
               state_in = ST_COMMIT;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_COMMIT: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/jddq_dpath.sv -----
// Datapath of the joystick dead-zone direction qualifier: settings, history,
// dead zones, two bit-serial dividers, tilt and edge logic, output register.
`default_nettype none

module jddq_dpath #(
   parameter int FULL_SCALE      = 100,
   parameter int PRESS_THRESHOLD = 50
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire jddq_pkg::jddq_cmd_type   cmd,
   output jddq_pkg::jddq_status_type     status,
   input  wire logic                     csr_write,
   input  wire logic [2:0]               csr_index,
   input  wire logic [7:0]               csr_data,
   input  wire logic [7:0]               req_stick_x,
   input  wire logic [7:0]               req_stick_y,
   input  wire logic signed [12:0]       req_roll_angle,
   input  wire logic signed [12:0]       req_pitch_angle,
   input  wire logic                     req_button_z_down,
   input  wire logic                     req_button_c_down,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [1:0]             rsp_dir_x,
   output logic signed [1:0]             rsp_dir_y,
   output logic                          rsp_moving,
   output logic signed [15:0]            rsp_percent_x,
   output logic signed [15:0]            rsp_percent_y,
   output logic [3:0]                    rsp_direction_bits,
   output logic [3:0]                    rsp_dir_pressed,
   output logic [3:0]                    rsp_dir_released,
   output logic                          rsp_side_tilted,
   output logic                          rsp_tilted_up,
   output logic                          rsp_tilted_down,
   output logic [3:0]                    rsp_button_edges
);
   import jddq_pkg::*;

   localparam int MUL_W   = $clog2(255 * FULL_SCALE + 1);
   localparam int NUM_W   = MUL_W + 8;
   localparam int CMP_W   = MUL_W + 8;
   localparam int LIM_RAW = FULL_SCALE * 256;
   localparam int LIM     = (LIM_RAW > 32767) ? 32767 : LIM_RAW;
   localparam logic [NUM_W-1:0] LIM_WIDE = NUM_W'(LIM);
   localparam logic [15:0]      LIM_16   = 16'(LIM);

   // Settings and history.
   logic [7:0] dead_high_ff [AXES];
   logic [7:0] dead_low_ff  [AXES];
   logic [7:0] span_high_ff [AXES];
   logic [7:0] span_low_ff  [AXES];
   logic [7:0] last_stick_ff [AXES];
   logic       last_z_ff, last_c_ff;
   logic [3:0] last_dirs_ff;

   // Captured request.
   logic [7:0]        stick_ff [AXES];
   logic signed [12:0] roll_ff, pitch_ff;
   logic              z_ff, c_ff;

   // Per-axis working registers.
   logic [7:0]       d_ff    [AXES];
   logic [7:0]       span_ff [AXES];
   logic             pos_ff  [AXES];
   logic             neg_ff  [AXES];
   logic             beyond_ff [AXES];
   logic [NUM_W-1:0] quot_ff [AXES];
   logic [7:0]       rem_ff  [AXES];

   logic [7:0]       d_in    [AXES];
   logic [7:0]       span_in [AXES];
   logic             pos_in  [AXES];
   logic             neg_in  [AXES];
   logic             beyond_in [AXES];
   logic [NUM_W-1:0] quot_in [AXES];
   logic [7:0]       rem_in  [AXES];
   logic [15:0]      pct_in  [AXES];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       dirs_in;
   logic signed [1:0] dx_in, dy_in;
   logic             side_in, up_in, down_in;
   logic [3:0]       edges_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_high_ff[AXIS_X] <= DEAD_HIGH_RESET;
         dead_high_ff[AXIS_Y] <= DEAD_HIGH_RESET;
         dead_low_ff[AXIS_X]  <= DEAD_LOW_RESET;
         dead_low_ff[AXIS_Y]  <= DEAD_LOW_RESET;
         span_high_ff[AXIS_X] <= SPAN_HIGH_RESET;
         span_high_ff[AXIS_Y] <= SPAN_HIGH_RESET;
         span_low_ff[AXIS_X]  <= SPAN_LOW_RESET;
         span_low_ff[AXIS_Y]  <= SPAN_LOW_RESET;
      end else if (csr_write) begin
         unique case (jddq_reg_type'(csr_index))
            REG_DEAD_HIGH_X: dead_high_ff[AXIS_X] <= csr_data;
            REG_DEAD_LOW_X:  dead_low_ff[AXIS_X]  <= csr_data;
            REG_DEAD_HIGH_Y: dead_high_ff[AXIS_Y] <= csr_data;
            REG_DEAD_LOW_Y:  dead_low_ff[AXIS_Y]  <= csr_data;
            REG_SPAN_HIGH_X: span_high_ff[AXIS_X] <= csr_data;
            REG_SPAN_LOW_X:  span_low_ff[AXIS_X]  <= csr_data;
            REG_SPAN_HIGH_Y: span_high_ff[AXIS_Y] <= csr_data;
            REG_SPAN_LOW_Y:  span_low_ff[AXIS_Y]  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stick_ff[AXIS_X] <= '0;
         last_stick_ff[AXIS_Y] <= '0;
         last_z_ff             <= 1'b0;
         last_c_ff             <= 1'b0;
         last_dirs_ff          <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            last_stick_ff[AXIS_X] <= stick_ff[AXIS_X];
            last_stick_ff[AXIS_Y] <= stick_ff[AXIS_Y];
            last_z_ff             <= z_ff;
            last_c_ff             <= c_ff;
            last_dirs_ff          <= dirs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         stick_ff[AXIS_X] <= req_stick_x;
         stick_ff[AXIS_Y] <= req_stick_y;
         roll_ff          <= req_roll_angle;
         pitch_ff         <= req_pitch_angle;
         z_ff             <= req_button_z_down;
         c_ff             <= req_button_c_down;
      end
      for (int i = 0; i < AXES; i++) begin
         if (cmd.setup) begin
            d_ff[i]    <= d_in[i];
            span_ff[i] <= span_in[i];
            pos_ff[i]  <= pos_in[i];
            neg_ff[i]  <= neg_in[i];
         end
         if (cmd.prep) begin
            beyond_ff[i] <= beyond_in[i];
         end
         if (cmd.prep || cmd.step) begin
            quot_ff[i] <= quot_in[i];
            rem_ff[i]  <= rem_in[i];
         end
      end
      if (cmd.commit) begin
         rsp_dir_x          <= dx_in;
         rsp_dir_y          <= dy_in;
         rsp_moving         <= (dx_in != 2'sd0) || (dy_in != 2'sd0);
         rsp_percent_x      <= pct_in[AXIS_X];
         rsp_percent_y      <= pct_in[AXIS_Y];
         rsp_direction_bits <= dirs_in;
         rsp_dir_pressed    <= (dirs_in != last_dirs_ff) ? dirs_in : 4'd0;
         rsp_dir_released   <= (dirs_in != last_dirs_ff) ? ~dirs_in : 4'd0;
         rsp_side_tilted    <= side_in;
         rsp_tilted_up      <= up_in;
         rsp_tilted_down    <= down_in;
         rsp_button_edges   <= edges_in;
      end
   end

   // Dead zone, travel and span selection.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         pos_in[i]  = 1'b0;
         neg_in[i]  = 1'b0;
         d_in[i]    = '0;
         span_in[i] = span_low_ff[i];
         if (stick_ff[i] < dead_high_ff[i] && stick_ff[i] > dead_low_ff[i]) begin
            span_in[i] = span_high_ff[i];
         end else if (stick_ff[i] >= dead_high_ff[i]) begin
            pos_in[i]  = 1'b1;
            d_in[i]    = stick_ff[i] - dead_high_ff[i];
            span_in[i] = span_high_ff[i];
         end else begin
            neg_in[i]  = 1'b1;
            d_in[i]    = dead_low_ff[i] - stick_ff[i];
         end
      end
   end

   // Numerator load, threshold compare and one restoring division step.
   always_comb begin
      logic [MUL_W-1:0] prod;
      logic [8:0]       rem_shift;
      logic [8:0]       span9;
      logic             ge;
      for (int i = 0; i < AXES; i++) begin
         prod      = MUL_W'(d_ff[i]) * MUL_W'(FULL_SCALE);
         beyond_in[i] = (CMP_W'(d_ff[i]) * CMP_W'(FULL_SCALE)) >
                        (CMP_W'(PRESS_THRESHOLD) * CMP_W'(span_ff[i]));
         rem_shift = {rem_ff[i], quot_ff[i][NUM_W-1]};
         span9     = {1'b0, span_ff[i]};
         ge        = (rem_shift >= span9);
         if (cmd.prep) begin
            quot_in[i] = {prod, 8'd0};
            rem_in[i]  = '0;
         end else begin
            quot_in[i] = {quot_ff[i][NUM_W-2:0], ge};
            rem_in[i]  = ge ? 8'(rem_shift - span9) : rem_shift[7:0];
         end
      end
   end

   // Result assembly.
   always_comb begin
      logic [15:0] mag;
      for (int i = 0; i < AXES; i++) begin
         mag = (quot_ff[i] > LIM_WIDE) ? LIM_16 : quot_ff[i][15:0];
         if (d_ff[i] == 8'd0) begin
            pct_in[i] = '0;
         end else if (neg_ff[i]) begin
            pct_in[i] = 16'(-mag);
         end else begin
            pct_in[i] = mag;
         end
      end

      dirs_in = {beyond_ff[AXIS_Y] & neg_ff[AXIS_Y], beyond_ff[AXIS_Y] & pos_ff[AXIS_Y],
                 beyond_ff[AXIS_X] & neg_ff[AXIS_X], beyond_ff[AXIS_X] & pos_ff[AXIS_X]};

      dx_in = 2'sd0;
      if (last_stick_ff[AXIS_X] != 8'd0) begin
         if (pos_ff[AXIS_X]) begin
            dx_in = 2'sd1;
         end else if (neg_ff[AXIS_X]) begin
            dx_in = -2'sd1;
         end
      end
      dy_in = 2'sd0;
      if (last_stick_ff[AXIS_Y] != 8'd0) begin
         if (pos_ff[AXIS_Y]) begin
            dy_in = -2'sd1;
         end else if (neg_ff[AXIS_Y]) begin
            dy_in = 2'sd1;
         end
      end

      side_in = ((roll_ff > ROLL_SIDE_MIN && roll_ff < ROLL_SIDE_MAX) ||
                 (roll_ff > -ROLL_SIDE_MAX && roll_ff < -ROLL_SIDE_MIN)) &&
                (pitch_ff > -PITCH_FLAT_MAX && pitch_ff < PITCH_FLAT_MAX);
      up_in   = (pitch_ff > PITCH_TILT_MIN && pitch_ff < PITCH_TILT_MAX);
      down_in = (pitch_ff > -PITCH_TILT_MAX && pitch_ff < -PITCH_TILT_MIN);

      edges_in = {~c_ff & last_c_ff, c_ff & ~last_c_ff,
                  ~z_ff & last_z_ff, z_ff & ~last_z_ff};
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_busy = rsp_valid_ff & rsp_stall;

endmodule

`default_nettype wire

// ----- hdl/joystick_deadzone_direction_qualifier_unit.sv -----
// A request is captured, then the controller runs setup, prep, the divide steps
// and commit; W = clog2(255 * FULL_SCALE + 1) + 8 is the step count of the bit-serial
// dividers (23 at the default), one quotient bit per cycle for both axes at once.
// A new request is taken only after the previous one has been committed.
// Reset (synchronous, active high) restores the settings and clears the history.
// Top level: joins the controller jddq_ctrl and the datapath jddq_dpath.
`default_nettype none

module joystick_deadzone_direction_qualifier_unit #(
   parameter int FULL_SCALE      = 100,
   parameter int PRESS_THRESHOLD = 50
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [7:0]         csr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_stick_x,
   input  wire logic [7:0]         req_stick_y,
   input  wire logic signed [12:0] req_roll_angle,
   input  wire logic signed [12:0] req_pitch_angle,
   input  wire logic               req_button_z_down,
   input  wire logic               req_button_c_down,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [1:0]       rsp_dir_x,
   output logic signed [1:0]       rsp_dir_y,
   output logic                    rsp_moving,
   output logic signed [15:0]      rsp_percent_x,
   output logic signed [15:0]      rsp_percent_y,
   output logic [3:0]              rsp_direction_bits,
   output logic [3:0]              rsp_dir_pressed,
   output logic [3:0]              rsp_dir_released,
   output logic                    rsp_side_tilted,
   output logic                    rsp_tilted_up,
   output logic                    rsp_tilted_down,
   output logic [3:0]              rsp_button_edges
);
   import jddq_pkg::*;

   localparam int DIV_STEPS = $clog2(255 * FULL_SCALE + 1) + 8;

   jddq_cmd_type    cmd;
   jddq_status_type status;

   jddq_ctrl #(
      .DIV_STEPS(DIV_STEPS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   jddq_dpath #(
      .FULL_SCALE     (FULL_SCALE),
      .PRESS_THRESHOLD(PRESS_THRESHOLD)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_stick_x       (req_stick_x),
      .req_stick_y       (req_stick_y),
      .req_roll_angle    (req_roll_angle),
      .req_pitch_angle   (req_pitch_angle),
      .req_button_z_down (req_button_z_down),
      .req_button_c_down (req_button_c_down),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dir_x         (rsp_dir_x),
      .rsp_dir_y         (rsp_dir_y),
      .rsp_moving        (rsp_moving),
      .rsp_percent_x     (rsp_percent_x),
      .rsp_percent_y     (rsp_percent_y),
      .rsp_direction_bits(rsp_direction_bits),
      .rsp_dir_pressed   (rsp_dir_pressed),
      .rsp_dir_released  (rsp_dir_released),
      .rsp_side_tilted   (rsp_side_tilted),
      .rsp_tilted_up     (rsp_tilted_up),
      .rsp_tilted_down   (rsp_tilted_down),
      .rsp_button_edges  (rsp_button_edges)
   );

endmodule

`default_nettype wire
